[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high
`define BPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion, checked during reset too
`define BPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Constants, codes and controller/datapath types of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS  = 32768;
  localparam int BLOCK_BYTES = 4096;
  localparam int WORD_BITS   = 32;

  localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
  localparam int WIDX_W      = $clog2(MAP_WORDS);
  localparam int PTR_W       = WIDX_W + 1;
  localparam int BLK_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = BLK_W + 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

  // Payload field widths
  localparam int OPCODE_W    = 3;
  localparam int ADDR_W      = 27;
  localparam int LEN_W       = 28;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  // Operation codes; the two unused codes act as query
  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_RESERVE = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_FILL,
    ST_SCAN,
    ST_REGION,
    ST_FINISH
  } state_t;

  // Map write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ONES,
    WR_REGION,
    WR_ALLOC
  } wr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    prep;
    logic    ptr_inc;
    logic    rd_en;
    wr_sel_t wr_sel;
    logic    count_apply;
    logic    load_result;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                cnt_zero;
    logic                ptr_at_end;
    logic                ptr_at_last;
    logic                rd_valid;
    logic                rd_hit;
  } dp_sts_t;

endpackage

[rtl/core/bpa_req_if.sv]
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: operation code, byte address and length.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   byte_address;
  logic [LEN_W-1:0]    length_bytes;

  modport source (output valid, output opcode, output byte_address,
                  output length_bytes, input ready);
  modport sink   (input valid, input opcode, input byte_address,
                  input length_bytes, output ready);
endinterface

[rtl/core/bpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Response channel: allocated address, status and byte statistics.
// ----------------------------------------------------------------------------
interface bpa_rsp_if import bpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  logic              alloc_ok;
  logic [LEN_W-1:0]  used_bytes;
  logic [LEN_W-1:0]  free_bytes;
  logic [LEN_W-1:0]  total_bytes;

  modport source (output valid, output block_address, output alloc_ok,
                  output used_bytes, output free_bytes, output total_bytes,
                  input ready);
  modport sink   (input valid, input block_address, input alloc_ok,
                  input used_bytes, input free_bytes, input total_bytes,
                  output ready);
endinterface

[rtl/core/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: clearing pass, word sweeps, allocation scan and result handoff.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_result | (out_valid & ~out_ready);
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        // set every map word to used, one word a cycle
        cmd.wr_sel  = WR_ONES;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_at_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        case (sts.op)
          OP_INIT:  state_next = ST_FILL;
          OP_ALLOC: state_next = ST_SCAN;
          OP_FREE, OP_RELEASE, OP_RESERVE: begin
            state_next = sts.cnt_zero ? ST_FINISH : ST_REGION;
          end
          default:  state_next = ST_FINISH;
        endcase
      end
      ST_FILL: begin
        if (sts.ptr_at_end) begin
          state_next = ST_FINISH;
        end else begin
          cmd.wr_sel  = WR_ONES;
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        // stream reads, stop on the first word with a clear bit or at the end of the pool
        if (sts.rd_hit) begin
          cmd.wr_sel = WR_ALLOC;
          state_next = ST_FINISH;
        end else if (sts.ptr_at_end) begin
          state_next = ST_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_REGION: begin
        // read ahead one word, write back the word read last cycle
        cmd.rd_en = ~sts.ptr_at_end;
        if (sts.rd_valid) begin
          cmd.wr_sel = WR_REGION;
        end
        if (sts.ptr_at_end && !sts.rd_valid) begin
          cmd.count_apply = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bpa_datapath.sv]
// ----------------------------------------------------------------------------
// bpa_datapath
// Block map memory, word pointer, masks, block counters and result register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [ADDR_W-1:0]   byte_address,
  input  logic [LEN_W-1:0]    length_bytes,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic [ADDR_W-1:0]   block_address,
  output logic                alloc_ok,
  output logic [LEN_W-1:0]    used_bytes,
  output logic [LEN_W-1:0]    free_bytes,
  output logic [LEN_W-1:0]    total_bytes
);

  localparam int NRAW_W = LEN_W - BLK_SHIFT;

  // Request registers
  logic [OPCODE_W-1:0]  op_q;
  logic [BLK_W-1:0]     lo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [BLK_W-1:0]     last_q;
  logic [PTR_W-1:0]     end_q;

  // Sweep pointer and read pipeline
  logic [PTR_W-1:0]     ptr;
  logic                 rd_valid_q;
  logic [WIDX_W-1:0]    rd_ptr_q;
  logic [WORD_BITS-1:0] rd_data;

  // Pool state
  logic [CNT_W-1:0]     pool;
  logic [CNT_W-1:0]     used;
  logic                 ok_q;
  logic [BLK_W-1:0]     blk_q;

  // Request decode
  logic [NRAW_W-1:0]    n_raw;
  logic [CNT_W-1:0]     n_clamp;
  logic [BLK_W-1:0]     blk_in;
  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     cnt_in;
  logic                 is_region;
  logic [CNT_W-1:0]     last_sum;
  logic [PTR_W-1:0]     pool_words;

  // Map write side
  logic                 we;
  logic [WIDX_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] run_mask;
  logic [BIT_W-1:0]     free_idx;
  logic [CNT_W:0]       up_sum;

  // Lowest clear bit of a word
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!v[j]) begin
        idx = BIT_W'(j);
      end
    end
    return idx;
  endfunction

  // Decode block count and run length from the request
  assign n_raw     = length_bytes[LEN_W-1:BLK_SHIFT];
  assign n_clamp   = (n_raw > NRAW_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(n_raw);
  assign blk_in    = BLK_W'(byte_address >> BLK_SHIFT);
  assign room      = CNT_W'(MAX_BLOCKS) - CNT_W'(blk_in);
  assign cnt_in    = (opcode == OP_FREE) ? CNT_W'(1) :
                     ((n_clamp < room) ? n_clamp : room);
  assign is_region = (op_q == OP_FREE) || (op_q == OP_RELEASE) || (op_q == OP_RESERVE);
  assign last_sum  = CNT_W'(lo_q) + cnt_q - CNT_W'(1);
  assign pool_words = PTR_W'(pool >> BIT_W);

  // Capture the request, set up the sweep bounds
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      lo_q  <= blk_in;
      cnt_q <= cnt_in;
    end
    if (cmd.prep) begin
      last_q <= BLK_W'(last_sum);
      if (is_region) begin
        end_q <= PTR_W'(last_sum[BLK_W-1:BIT_W]) + PTR_W'(1);
      end else begin
        end_q <= pool_words;
      end
    end
  end

  // Word pointer and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd.rd_en;
      if (cmd.prep) begin
        ptr <= is_region ? PTR_W'(lo_q[BLK_W-1:BIT_W]) : '0;
      end else if (cmd.ptr_inc || cmd.rd_en) begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ptr_q <= ptr[WIDX_W-1:0];
    end
  end

  // Run mask for the word being written back
  assign lo_mask  = (rd_ptr_q == lo_q[BLK_W-1:BIT_W]) ?
                    (FULL_WORD << lo_q[BIT_W-1:0]) : FULL_WORD;
  assign hi_mask  = (rd_ptr_q == last_q[BLK_W-1:BIT_W]) ?
                    (FULL_WORD >> (~last_q[BIT_W-1:0])) : FULL_WORD;
  assign run_mask = lo_mask & hi_mask;
  assign free_idx = lowest_zero(rd_data);

  // Select the map write
  always_comb begin
    we    = 1'b0;
    waddr = ptr[WIDX_W-1:0];
    wdata = FULL_WORD;
    case (cmd.wr_sel)
      WR_ONES: begin
        we = 1'b1;
      end
      WR_REGION: begin
        we    = rd_valid_q;
        waddr = rd_ptr_q;
        wdata = (op_q == OP_RESERVE) ? (rd_data | run_mask) : (rd_data & ~run_mask);
      end
      WR_ALLOC: begin
        we    = 1'b1;
        waddr = rd_ptr_q;
        wdata = rd_data | (WORD_BITS'(1) << free_idx);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (ptr[WIDX_W-1:0]),
    .rdata (rd_data)
  );

  // Pool size and used count
  assign up_sum = (CNT_W+1)'(used) + (CNT_W+1)'(cnt_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= '0;
      used <= '0;
    end else if (cmd.capture && (opcode == OP_INIT)) begin
      pool <= n_clamp;
      used <= n_clamp;
    end else if (cmd.wr_sel == WR_ALLOC) begin
      if (used < pool) begin
        used <= used + CNT_W'(1);
      end
    end else if (cmd.count_apply) begin
      if (op_q == OP_RESERVE) begin
        used <= (up_sum > (CNT_W+1)'(pool)) ? pool : CNT_W'(up_sum);
      end else begin
        used <= (used > cnt_q) ? (used - cnt_q) : '0;
      end
    end
  end

  // Allocation outcome
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok_q  <= 1'b0;
      blk_q <= '0;
    end else if (cmd.wr_sel == WR_ALLOC) begin
      ok_q  <= 1'b1;
      blk_q <= {rd_ptr_q, free_idx};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      block_address <= ADDR_W'(blk_q) << BLK_SHIFT;
      alloc_ok      <= ok_q;
      used_bytes    <= LEN_W'(used) << BLK_SHIFT;
      free_bytes    <= LEN_W'(pool - used) << BLK_SHIFT;
      total_bytes   <= LEN_W'(pool) << BLK_SHIFT;
    end
  end

  // Status
  assign sts.op          = op_q;
  assign sts.cnt_zero    = (cnt_q == '0);
  assign sts.ptr_at_end  = (ptr == end_q);
  assign sts.ptr_at_last = (ptr == PTR_W'(MAP_WORDS - 1));
  assign sts.rd_valid    = rd_valid_q;
  assign sts.rd_hit      = rd_valid_q && (rd_data != FULL_WORD);

endmodule

[rtl/core/bitmap_page_allocator.sv]
// A request is captured and prepared, then sweeps the map words (init: pool/32 words; alloc:
// words up to the first with a free block; region ops: words spanned), then loads the result
// register; a query or an empty region skips the sweep. One request is in flight at a time;
// a new request is taken only once the previous result is loaded into the output register.
// A stalled result holds back the loading of the next result until it is taken.
// Synchronous reset, then a clearing pass marks every block used; no request taken.
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit block allocator over a used/free bitmap of 4 KiB blocks.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Map, counters and result register
  bpa_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (req.opcode),
    .byte_address  (req.byte_address),
    .length_bytes  (req.length_bytes),
    .cmd           (cmd),
    .sts           (sts),
    .block_address (rsp.block_address),
    .alloc_ok      (rsp.alloc_ok),
    .used_bytes    (rsp.used_bytes),
    .free_bytes    (rsp.free_bytes),
    .total_bytes   (rsp.total_bytes)
  );

endmodule

[rtl/core/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpa_checker import bpa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] block_address,
  input logic              alloc_ok,
  input logic [LEN_W-1:0]  used_bytes,
  input logic [LEN_W-1:0]  free_bytes,
  input logic [LEN_W-1:0]  total_bytes
);

  logic [LEN_W:0]                   bytes_sum;
  logic                             sum_ok;
  logic                             addr_zero;
  logic                             in_pool;
  logic                             stall;
  logic [ADDR_W+1+3*LEN_W-1:0]      rsp_bits;

  // Derive the terms the checks compare
  assign bytes_sum = (LEN_W+1)'(used_bytes) + (LEN_W+1)'(free_bytes);
  assign sum_ok    = (bytes_sum == (LEN_W+1)'(total_bytes));
  assign addr_zero = (block_address == '0);
  assign in_pool   = ((LEN_W)'(block_address) < total_bytes);
  assign stall     = out_valid && !out_ready;
  assign rsp_bits  = {block_address, alloc_ok, used_bytes, free_bytes, total_bytes};

  // No request is taken right after reset, at the start of the clearing pass
  `BPA_ASSERT_ALWAYS(a_clear_blocks_req, clk, rst |=> !in_ready, "request taken during clear")

  // Used and free add up to the pool in every valid result
  `BPA_ASSERT(a_bytes_sum, clk, rst, out_valid |-> sum_ok, "used plus free differs from total")

  // A failed or non-alloc result carries a zero address
  `BPA_ASSERT(a_addr_zero, clk, rst, (out_valid && !alloc_ok) |-> addr_zero, "stray address")

  // An allocated block lies inside the pool
  `BPA_ASSERT(a_addr_in_pool, clk, rst, (out_valid && alloc_ok) |-> in_pool, "block outside pool")

  // A stalled result holds
  `BPA_ASSERT(a_result_hold, clk, rst, stall |=> (out_valid && $stable(rsp_bits)), "result changed")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .block_address (rsp.block_address),
  .alloc_ok      (rsp.alloc_ok),
  .used_bytes    (rsp.used_bytes),
  .free_bytes    (rsp.free_bytes),
  .total_bytes   (rsp.total_bytes)
);
